[sv/dfpt_pkg.sv]
// Package for the deframer with peer table: sizes, byte codes, FSM state
// and the command/status bundles between controller and datapath.
// No dependencies.
package dfpt_pkg;

  // Frame and table sizes
  localparam int MAX_FRAME  = 64;
  localparam int MIN_FRAME  = 2;
  localparam int PEER_SLOTS = 16;

  localparam int LEN_W  = $clog2(MAX_FRAME + 1);
  localparam int ADDR_W = $clog2(MAX_FRAME);
  localparam int SLOT_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

  // Byte codes and reset port
  localparam logic [7:0]  START_LOW  = 8'h80;
  localparam logic [7:0]  END_BYTE   = 8'hFF;
  localparam logic [15:0] PORT_RESET = 16'd34848;

  // Input commands
  localparam logic CMD_BYTE   = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } dfpt_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic scan_step;  // advance table scan
    logic take_hit;   // sender found at scan index
    logic learn;      // write sender into first free slot
    logic emit_load;  // load output register from frame store
  } dfpt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic deliver_now; // current input closes a frame long enough to emit
    logic scan_hit;
    logic scan_last;
    logic scan_free;   // a free slot was seen so far, including this one
    logic emit_last;
    logic out_free;    // output register can take a byte
  } dfpt_sts_t;

endpackage

[sv/deframer_with_peer_table.sv]
// Deframer with peer table.
// Input channel (in_valid/in_stall): one received byte tagged with source
// address and port, or a remove command that frees one peer slot. Bytes
// from a port other than the configured port are ignored. A frame opens
// with a byte 0x80..0xFE and closes with 0xFF; short and overlong frames
// are dropped.
// Output channel (out_valid/out_stall): each complete frame whose sender
// has or gets a peer slot, byte by byte in order, with out_last on the
// closing byte, that slot and a flag that this frame learned the sender.
// Config channel (cfg_valid/cfg_ready): writes the accepted port; always
// ready, write only while the block is idle.
// Timing: a byte that does not close a frame, and a remove command, do
// not stall the input. A closing byte starts a table scan of one slot per
// cycle, then a read of the frame store, then one frame byte per cycle
// while the receiver takes them; the input is stalled for that whole time.
// A stalled receiver holds the output register and the emit sequence.
// Reset empties the peer table, clears the frame length and sets the
// accepted port to 34848. Depends on dfpt_pkg, dfpt_ctrl, dfpt_dp.
module deframer_with_peer_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_source_address,
  input  logic [15:0] in_source_port,
  input  logic [3:0]  in_slot_to_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_last,
  output logic [3:0]  out_peer_slot,
  output logic        out_new_peer
);
  import dfpt_pkg::*;

  dfpt_cmd_t   cmd;
  dfpt_sts_t   sts;
  dfpt_state_t state;

  assign cfg_ready = 1'b1;

  // Controller
  dfpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state),
    .in_stall (in_stall)
  );

  // Datapath
  dfpt_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_wr            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .in_command        (in_command),
    .in_data_byte      (in_data_byte),
    .in_source_address (in_source_address),
    .in_source_port    (in_source_port),
    .in_slot_to_free   (in_slot_to_free),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_frame_byte    (out_frame_byte),
    .out_last          (out_last),
    .out_peer_slot     (out_peer_slot),
    .out_new_peer      (out_new_peer)
  );

  // A new output byte appears only out of the emit state
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state == ST_EMIT_OUT))
    else $error("output valid rose outside emission");

  // A scan starts only from idle
  a_scan_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_SCAN) && !$past(state == ST_SCAN) |-> $past(state == ST_IDLE))
    else $error("table scan entered from wrong state");

  // Emission ends with the closing byte in the output register
  a_emit_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_IDLE) && $past(state == ST_EMIT_OUT) |-> out_valid && out_last)
    else $error("emission ended without last byte");

endmodule

[sv/dfpt_ctrl.sv]
// Controller FSM of the deframer: sequences input transfer, peer table
// scan and frame emission. Depends on dfpt_pkg.
module dfpt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  dfpt_pkg::dfpt_sts_t    sts,
  output dfpt_pkg::dfpt_cmd_t    cmd,
  output dfpt_pkg::dfpt_state_t  state,
  output logic                   in_stall
);
  import dfpt_pkg::*;

  dfpt_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.deliver_now) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_hit) begin
          state_nxt = ST_EMIT_RD;
        end else if (sts.scan_last) begin
          state_nxt = sts.scan_free ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (sts.out_free && sts.emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_SCAN: begin
        cmd.take_hit  = sts.scan_hit;
        cmd.learn     = !sts.scan_hit && sts.scan_last && sts.scan_free;
        cmd.scan_step = !sts.scan_hit && !sts.scan_last;
      end
      ST_EMIT_RD: begin
        cmd = '0;
      end
      ST_EMIT_OUT: begin
        cmd.emit_load = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  assign state = state_r;

endmodule

[sv/dfpt_dp.sv]
// Datapath of the deframer: port register, frame length, frame store
// memory, peer table, scan and emit counters, output register.
// Depends on dfpt_pkg.
module dfpt_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dfpt_pkg::dfpt_cmd_t  cmd,
  output dfpt_pkg::dfpt_sts_t  sts,
  input  logic                 cfg_wr,
  input  logic [15:0]          cfg_data,
  input  logic                 in_command,
  input  logic [7:0]           in_data_byte,
  input  logic [31:0]          in_source_address,
  input  logic [15:0]          in_source_port,
  input  logic [3:0]           in_slot_to_free,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [7:0]           out_frame_byte,
  output logic                 out_last,
  output logic [3:0]           out_peer_slot,
  output logic                 out_new_peer
);
  import dfpt_pkg::*;

  logic [15:0]       accepted_port_r;
  logic [LEN_W-1:0]  frame_len_r, frame_len_nxt;
  logic [LEN_W-1:0]  len_inc;
  logic [7:0]        frame_mem [MAX_FRAME];
  logic [7:0]        rdata_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              store_ok, is_end, mem_wr;

  logic [31:0]       peer_addr_r [PEER_SLOTS];
  logic [15:0]       peer_port_r [PEER_SLOTS];
  logic [31:0]       snd_addr_r;
  logic [15:0]       snd_port_r;
  logic [SLOT_W-1:0] scan_idx_r, free_slot_r, slot_r, free_sel;
  logic              have_free_r, new_r, entry_free, remove_ok;

  logic [LEN_W-1:0]  emit_cnt_r;
  logic [ADDR_W-1:0] emit_idx_r;

  logic              out_valid_r, out_last_r, out_new_r;
  logic [7:0]        out_byte_r;
  logic [3:0]        out_slot_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accepted_port_r <= PORT_RESET;
    end else if (cfg_wr) begin
      accepted_port_r <= cfg_data;
    end
  end

  // Decode received byte
  assign is_end   = (in_data_byte == END_BYTE);
  assign len_inc  = frame_len_r + LEN_W'(1);
  assign store_ok = (in_command == CMD_BYTE) && (in_source_port == accepted_port_r) &&
                    ((frame_len_r != '0) || ((in_data_byte >= START_LOW) && !is_end));
  assign mem_wr   = cmd.accept && store_ok && (frame_len_r < LEN_W'(MAX_FRAME));
  assign sts.deliver_now = store_ok && is_end && (len_inc >= LEN_W'(MIN_FRAME));

  // Advance or clear frame length
  always_comb begin
    frame_len_nxt = frame_len_r;
    if (cmd.accept && store_ok) begin
      if (is_end || (len_inc >= LEN_W'(MAX_FRAME))) begin
        frame_len_nxt = '0;
      end else begin
        frame_len_nxt = len_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= '0;
    end else begin
      frame_len_r <= frame_len_nxt;
    end
  end

  // Frame store: one write, one registered read
  assign rd_addr = cmd.emit_load ? (emit_idx_r + ADDR_W'(1)) : emit_idx_r;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      frame_mem[frame_len_r[ADDR_W-1:0]] <= in_data_byte;
    end
    rdata_r <= frame_mem[rd_addr];
  end

  // Latch sender and frame size when a frame closes
  always_ff @(posedge clk) begin
    if (cmd.accept && sts.deliver_now) begin
      snd_addr_r <= in_source_address;
      snd_port_r <= in_source_port;
      emit_cnt_r <= len_inc;
    end
  end

  // Table scan, one slot per cycle
  assign entry_free    = (peer_addr_r[scan_idx_r] == '0);
  assign sts.scan_hit  = (peer_addr_r[scan_idx_r] == snd_addr_r) &&
                         (peer_port_r[scan_idx_r] == snd_port_r);
  assign sts.scan_last = (scan_idx_r == SLOT_W'(PEER_SLOTS - 1));
  assign sts.scan_free = have_free_r || entry_free;
  assign free_sel      = have_free_r ? free_slot_r : scan_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r  <= '0;
      have_free_r <= 1'b0;
    end else if (cmd.accept && sts.deliver_now) begin
      scan_idx_r  <= '0;
      have_free_r <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + SLOT_W'(1);
      if (!have_free_r && entry_free) begin
        have_free_r <= 1'b1;
        free_slot_r <= scan_idx_r;
      end
    end
  end

  // Hold found or learned slot
  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      slot_r <= scan_idx_r;
      new_r  <= 1'b0;
    end else if (cmd.learn) begin
      slot_r <= free_sel;
      new_r  <= 1'b1;
    end
  end

  // Peer table: remove in idle, learn at end of scan
  assign remove_ok = cmd.accept && (in_command == CMD_REMOVE) &&
                     (int'(in_slot_to_free) < PEER_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PEER_SLOTS; i++) begin
        peer_addr_r[i] <= '0;
        peer_port_r[i] <= '0;
      end
    end else if (remove_ok) begin
      peer_addr_r[SLOT_W'(in_slot_to_free)] <= '0;
      peer_port_r[SLOT_W'(in_slot_to_free)] <= '0;
    end else if (cmd.learn) begin
      peer_addr_r[free_sel] <= snd_addr_r;
      peer_port_r[free_sel] <= snd_port_r;
    end
  end

  // Emit counter
  assign sts.emit_last = ((LEN_W'(emit_idx_r) + LEN_W'(1)) == emit_cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.take_hit || cmd.learn) begin
      emit_idx_r <= '0;
    end else if (cmd.emit_load) begin
      emit_idx_r <= emit_idx_r + ADDR_W'(1);
    end
  end

  // Output register: load on free slot, drop valid after transfer
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_byte_r <= rdata_r;
      out_last_r <= sts.emit_last;
      out_slot_r <= 4'(slot_r);
      out_new_r  <= new_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last       = out_last_r;
  assign out_peer_slot  = out_slot_r;
  assign out_new_peer   = out_new_r;

endmodule
